// ===== hdl/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker package
// Shared types and constants: channel payloads, the word record that passes
// from the word decoder to the merging stage, palette write bundle and codes.
// ----------------------------------------------------------------------------
package bpu_pkg;

    localparam int WORD_W      = 32;
    localparam int COORD_W     = 12;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 14;
    localparam int CODE_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int LANES       = 4;
    localparam int LANE_SLOTS  = 8;

    // Bits-per-pixel codes; code seven behaves as 32 bits per pixel.
    localparam logic [CODE_W-1:0] DEPTH_1  = 3'd0;
    localparam logic [CODE_W-1:0] DEPTH_2  = 3'd1;
    localparam logic [CODE_W-1:0] DEPTH_4  = 3'd2;
    localparam logic [CODE_W-1:0] DEPTH_8  = 3'd3;
    localparam logic [CODE_W-1:0] DEPTH_16 = 3'd4;
    localparam logic [CODE_W-1:0] DEPTH_24 = 3'd5;
    localparam logic [CODE_W-1:0] DEPTH_32 = 3'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEPTH  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               mode;
        logic [WORD_W-1:0]  data_word;
        logic [INDEX_W-1:0] palette_index;
    } bpu_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [WORD_W-1:0]  colour_word;
        logic               last_of_word;
    } bpu_out_t;

    // One decoded data word waiting to be split into pixels.
    typedef struct packed {
        logic               paletted;
        logic [CODE_W-1:0]  depth;
        logic [WORD_W-1:0]  data_word;
        logic [WORD_W-1:0]  colour0;
        logic [WORD_W-1:0]  colour1;
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] pixel_y;
    } word_rec_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } pal_wr_t;

    typedef logic [LANE_SLOTS-1:0][INDEX_W-1:0] lane_idx_t;

endpackage

// ===== hdl/bpu_lane.sv =====
// ----------------------------------------------------------------------------
// Byte lane
// Splits one file byte into its palette indices, most significant bit first,
// for the palette depths of 1, 2, 4 and 8 bits per pixel.
// ----------------------------------------------------------------------------
module bpu_lane (
    input  logic [bpu_pkg::CODE_W-1:0] depth,
    input  logic [7:0]                 lane_byte,
    output bpu_pkg::lane_idx_t         lane_idx
);
    import bpu_pkg::*;

    always_comb begin
        lane_idx = '0;
        case (depth)
            DEPTH_1: begin
                for (int k = 0; k < 8; k++) lane_idx[k] = {7'b0, lane_byte[7-k]};
            end
            DEPTH_2: begin
                for (int k = 0; k < 4; k++) lane_idx[k] = {6'b0, lane_byte[7-2*k -: 2]};
            end
            DEPTH_4: begin
                for (int k = 0; k < 2; k++) lane_idx[k] = {4'b0, lane_byte[7-4*k -: 4]};
            end
            DEPTH_8: begin
                lane_idx[0] = lane_byte;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/bpu_merge.sv =====
// ----------------------------------------------------------------------------
// Merging stage
// Holds one decoded word, runs the four byte lanes on it, walks its pixel slots one
// per unstalled cycle, looks palette pixels up and drives the result register.
// ----------------------------------------------------------------------------
module bpu_merge #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  bpu_pkg::word_rec_t  rec,
    output logic                load_ready,
    input  bpu_pkg::pal_wr_t    pal_wr,
    output logic                m_valid,
    input  logic                m_ready,
    output bpu_pkg::bpu_out_t   m_data
);
    import bpu_pkg::*;

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [WORD_W-1:0]  pal_mem [PALETTE_DEPTH];
    logic [WORD_W-1:0]  rd_reg;

    word_rec_t          buf_reg;
    logic               buf_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic               o_valid_reg;
    logic               o_pal_reg;
    logic [COORD_W-1:0] o_x_reg;
    logic [COORD_W-1:0] o_y_reg;
    logic [WORD_W-1:0]  o_colour_reg;
    logic               o_last_reg;

    lane_idx_t          lane_idx [LANES];
    logic [1:0]         lane_sel;
    logic [2:0]         pos;
    logic [INDEX_W-1:0] pick_idx;
    logic               idx_in_range;
    logic               last_slot;
    logic               issue;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bpu_lane u_lane (
            .depth     (buf_reg.depth),
            .lane_byte (buf_reg.data_word[8*g +: 8]),
            .lane_idx  (lane_idx[g])
        );
    end

    // Slot number to lane and position within the lane.
    always_comb begin
        case (buf_reg.depth)
            DEPTH_1: begin
                lane_sel = slot_reg[4:3];
                pos      = slot_reg[2:0];
            end
            DEPTH_2: begin
                lane_sel = slot_reg[3:2];
                pos      = {1'b0, slot_reg[1:0]};
            end
            DEPTH_4: begin
                lane_sel = slot_reg[2:1];
                pos      = {2'b0, slot_reg[0]};
            end
            default: begin
                lane_sel = slot_reg[1:0];
                pos      = 3'd0;
            end
        endcase
    end

    assign pick_idx     = lane_idx[lane_sel][pos];
    assign idx_in_range = (9'(pick_idx) < 9'(PALETTE_DEPTH));
    assign last_slot    = ((COUNT_W'(slot_reg) + COUNT_W'(1)) == buf_reg.count);
    assign issue        = buf_valid_reg && (!o_valid_reg || m_ready);
    assign load_ready   = !buf_valid_reg || (issue && last_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (load) begin
            buf_valid_reg <= 1'b1;
        end else if (issue && last_slot) begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg  <= rec;
            slot_reg <= '0;
        end else if (issue) begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // Palette memory; a read issued in the same cycle as a write sees the old word.
    always_ff @(posedge aclk) begin
        if (pal_wr.en) begin
            pal_mem[pal_wr.addr[ADDR_W-1:0]] <= pal_wr.data;
        end
        if (issue) begin
            rd_reg <= pal_mem[pick_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (issue) begin
            o_valid_reg <= 1'b1;
        end else if (m_ready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            o_x_reg    <= COORD_W'(buf_reg.start_x + COORD_W'(slot_reg));
            o_y_reg    <= buf_reg.pixel_y;
            o_last_reg <= last_slot;
            o_pal_reg  <= buf_reg.paletted && idx_in_range;
            if (buf_reg.paletted) begin
                o_colour_reg <= '0;
            end else if (slot_reg[0]) begin
                o_colour_reg <= buf_reg.colour1;
            end else begin
                o_colour_reg <= buf_reg.colour0;
            end
        end
    end

    assign m_valid             = o_valid_reg;
    assign m_data.pixel_x      = o_x_reg;
    assign m_data.pixel_y      = o_y_reg;
    assign m_data.colour_word  = o_pal_reg ? rd_reg : o_colour_reg;
    assign m_data.last_of_word = o_last_reg;

endmodule

// ===== hdl/bitmap_pixel_array_unpacker.sv =====
// ----------------------------------------------------------------------------
// Bitmap pixel array unpacker
// Decodes the pixel array of a device-independent bitmap into one colour
// transfer per pixel, with its column and top-down row.
// ----------------------------------------------------------------------------
// Data words arrive as little-endian 32-bit words in file order; mode-1
// transfers load the palette instead. Each data word is decoded in the cycle
// it is accepted and handed to a one-word buffer, where four byte lanes split
// it into pixel slots and the merging stage emits one pixel per cycle unless
// the output is stalled. A word yields 32, 16, 8 or 4 pixels at 1, 2, 4 or 8
// bits per pixel, two at 16 bits, one or two at 24 bits and one at 32 bits,
// fewer where the row ends; a padding word or any word after the last row is
// not loaded into the buffer. The next word is taken in the cycle its
// predecessor's final pixel leaves the buffer. The buffer and then the result
// register lie between an input transfer and its first result. Palette writes
// share the input channel and therefore never overtake earlier pixels.
// A write to any of the three configuration registers restarts the image
// (position and carry cleared); the palette is kept. Writes to the
// configuration index beyond the three registers are accepted and ignored.
// ----------------------------------------------------------------------------
module bitmap_pixel_array_unpacker #(
    parameter int MAX_DIMENSION = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bpu_pkg::bpu_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bpu_pkg::bpu_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bpu_pkg::*;

    // Configuration registers.
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CODE_W-1:0]   depth_reg;

    // Image position and the partial 24-bit pixel carried between words.
    logic [WIDTH_W-1:0]  col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [WIDTH_W-1:0]  word_pos_reg, word_pos_next;
    logic [23:0]         carry_reg, carry_next;
    logic [1:0]          carry_len_reg, carry_len_next;

    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] rows_raw;
    logic [HEIGHT_W-1:0] rows_eff;
    logic                upward;
    logic [17:0]         row_bits;
    logic [WIDTH_W-1:0]  stride_words;
    logic [HEIGHT_W-1:0] y_full;
    logic [WIDTH_W-1:0]  remaining;
    logic [COUNT_W-1:0]  slots;
    logic                row_active;
    logic                end_row;
    logic                in_xfer;
    logic                cfg_xfer;
    logic                cfg_known;

    word_rec_t           rec;
    logic                load;
    logic                load_ready;
    pal_wr_t             pal_wr;

    function automatic logic [WORD_W-1:0] expand_555(input logic [15:0] v);
        expand_555 = {8'h00, v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_ready   = load_ready;
    assign in_xfer   = s_valid && s_ready;

    // Image geometry: width clamped to one and to the largest dimension, row
    // count from the height's magnitude, sign giving the storage direction.
    always_comb begin
        width_eff = width_reg;
        if (width_reg == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (32'(width_reg) > MAX_DIMENSION) begin
            width_eff = WIDTH_W'(MAX_DIMENSION);
        end
        upward   = !height_reg[HEIGHT_W-1];
        rows_raw = upward ? height_reg : (HEIGHT_W'(0) - height_reg);
        rows_eff = (32'(rows_raw) > MAX_DIMENSION) ? HEIGHT_W'(MAX_DIMENSION) : rows_raw;
        case (depth_reg)
            DEPTH_1:  row_bits = 18'(width_eff);
            DEPTH_2:  row_bits = 18'(width_eff) << 1;
            DEPTH_4:  row_bits = 18'(width_eff) << 2;
            DEPTH_8:  row_bits = 18'(width_eff) << 3;
            DEPTH_16: row_bits = 18'(width_eff) << 4;
            DEPTH_24: row_bits = (18'(width_eff) << 4) + (18'(width_eff) << 3);
            default:  row_bits = 18'(width_eff) << 5;
        endcase
        // Rows are padded to whole words.
        stride_words = WIDTH_W'((19'(row_bits) + 19'd31) >> 5);
    end

    // Word decode. Rows end on word boundaries, so a whole word lies in one
    // row and the row changes only after the word's last byte.
    always_comb begin
        row_active = (row_reg < rows_eff);
        end_row    = ((HEIGHT_W'(word_pos_reg) + HEIGHT_W'(1)) >= HEIGHT_W'(stride_words));
        y_full     = upward ? (rows_eff - HEIGHT_W'(1) - row_reg) : row_reg;
        remaining  = width_eff - col_reg;

        rec.paletted  = !depth_reg[2];
        rec.depth     = depth_reg;
        rec.data_word = s_data.data_word;
        rec.start_x   = col_reg[COORD_W-1:0];
        rec.pixel_y   = y_full[COORD_W-1:0];
        rec.colour0   = s_data.data_word;
        rec.colour1   = s_data.data_word;
        carry_next     = '0;
        carry_len_next = 2'd0;

        case (depth_reg)
            DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8: begin
                slots = COUNT_W'(32) >> depth_reg[1:0];
            end
            DEPTH_16: begin
                slots       = COUNT_W'(2);
                rec.colour0 = expand_555(s_data.data_word[15:0]);
                rec.colour1 = expand_555(s_data.data_word[31:16]);
            end
            DEPTH_24: begin
                // A 24-bit pixel may begin in the previous word.
                case (carry_len_reg)
                    2'd0: begin
                        slots          = COUNT_W'(1);
                        rec.colour0    = {8'h00, s_data.data_word[23:0]};
                        carry_next     = {16'h0000, s_data.data_word[31:24]};
                        carry_len_next = 2'd1;
                    end
                    2'd1: begin
                        slots          = COUNT_W'(1);
                        rec.colour0    = {8'h00, s_data.data_word[15:0], carry_reg[7:0]};
                        carry_next     = {8'h00, s_data.data_word[31:16]};
                        carry_len_next = 2'd2;
                    end
                    default: begin
                        slots       = COUNT_W'(2);
                        rec.colour0 = {8'h00, s_data.data_word[7:0], carry_reg[15:0]};
                        rec.colour1 = {8'h00, s_data.data_word[31:8]};
                    end
                endcase
            end
            default: begin
                slots = COUNT_W'(1);
            end
        endcase

        // Pixels beyond the row's width are padding and are not emitted.
        rec.count = (WIDTH_W'(slots) > remaining) ? remaining[COUNT_W-1:0] : slots;

        if (end_row) begin
            col_next       = '0;
            row_next       = row_reg + HEIGHT_W'(1);
            word_pos_next  = '0;
            carry_next     = '0;
            carry_len_next = 2'd0;
        end else begin
            col_next      = col_reg + WIDTH_W'(rec.count);
            row_next      = row_reg;
            word_pos_next = word_pos_reg + WIDTH_W'(1);
        end
    end

    assign load = in_xfer && !cfg_xfer && !s_data.mode && row_active && (rec.count != '0);

    always_comb begin
        pal_wr.en   = in_xfer && s_data.mode && (9'(s_data.palette_index) < 9'(PALETTE_DEPTH));
        pal_wr.addr = s_data.palette_index;
        pal_wr.data = s_data.data_word;
    end

    always_comb begin
        unique case (cfg_index)
            CFG_WIDTH, CFG_HEIGHT, CFG_DEPTH: cfg_known = 1'b1;
            default:                          cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
            depth_reg  <= DEPTH_8;
        end else if (cfg_xfer) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_DEPTH:  depth_reg  <= cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_xfer && cfg_known)) begin
            col_reg       <= '0;
            row_reg       <= '0;
            word_pos_reg  <= '0;
            carry_reg     <= '0;
            carry_len_reg <= 2'd0;
        end else if (in_xfer && !s_data.mode && row_active) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            word_pos_reg  <= word_pos_next;
            carry_reg     <= carry_next;
            carry_len_reg <= carry_len_next;
        end
    end

    bpu_merge #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .rec        (rec),
        .load_ready (load_ready),
        .pal_wr     (pal_wr),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== hdl/bpu_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the unpacker's ports: reset behaviour, result stability and the
// column order of pixels that come from one word.
// ----------------------------------------------------------------------------
module bpu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input bpu_pkg::bpu_in_t                s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input bpu_pkg::bpu_out_t               m_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [bpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpu_pkg::*;

    logic               mid_word_reg;
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_y_reg;
    logic               out_xfer;

    assign out_xfer = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_word_reg <= 1'b0;
        end else if (out_xfer) begin
            mid_word_reg <= !m_data.last_of_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer) begin
            prev_x_reg <= m_data.pixel_x;
            prev_y_reg <= m_data.pixel_y;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result dropped or changed");

    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && mid_word_reg) |->
        ((m_data.pixel_x == COORD_W'(prev_x_reg + COORD_W'(1))) &&
         (m_data.pixel_y == prev_y_reg)))
        else $error("pixels of one word not in consecutive columns of one row");

    // Inputs watched by the bind but not needed by the properties above.
    logic unused_inputs;
    assign unused_inputs = s_valid ^ (^s_data) ^ cfg_valid ^ cfg_ready ^ (^cfg_index)
                         ^ (^cfg_data);

endmodule

bind bitmap_pixel_array_unpacker bpu_checker u_bpu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ===== test/tb_bitmap_pixel_array_unpacker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap pixel array unpacker testbench
// Drives palette loads and pixel-array words into the unpacker under random
// flow control on both channels, predicts every pixel transfer from a model
// of the decoder kept here, and checks the results field by field in order.
// ----------------------------------------------------------------------------
module tb_bitmap_pixel_array_unpacker;
    import bpu_pkg::*;

    localparam int MAX_DIMENSION   = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_PIXELS      = 32;
    localparam int RANDOM_ITEMS    = 350;
    // A padding word or a word past the last row is never loaded into the
    // block's buffer, so this comfortably covers the quiet tail after the
    // last expected pixel.
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE    = 2'd3;
    localparam logic [CODE_W-1:0]      DEPTH_WIDE   = 3'd7;
    localparam logic                   MODE_PIXELS  = 1'b0;
    localparam logic                   MODE_PALETTE = 1'b1;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioural copy of the decoder and the queue of pixels
    // that it says must come out, oldest first.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        bit [WORD_W-1:0]   palette [PALETTE_ENTRIES];
        bit [WIDTH_W-1:0]  width_reg;
        bit [HEIGHT_W-1:0] height_reg;
        bit [CODE_W-1:0]   depth_reg;
        int unsigned       column;
        int unsigned       row;
        int unsigned       row_bits;
        int unsigned       carry_len;
        bit [23:0]         carry;
        bpu_out_t          expected_pixels [$];
        int unsigned       error_count;
        int unsigned       live_items;

        function new();
            width_reg  = 1;
            height_reg = 1;
            depth_reg  = DEPTH_8;
            restart_image();
        endfunction

        function void restart_image();
            column    = 0;
            row       = 0;
            row_bits  = 0;
            carry     = '0;
            carry_len = 0;
        endfunction

        // Any write to one of the three registers restarts the image; the
        // spare index is accepted and changes nothing.
        function void apply_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_WIDTH:  width_reg  = value[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
                CFG_DEPTH:  depth_reg  = value[CODE_W-1:0];
                default:    return;
            endcase
            restart_image();
        endfunction

        function int unsigned bits_per_pixel();
            case (depth_reg)
                DEPTH_1:  return 1;
                DEPTH_2:  return 2;
                DEPTH_4:  return 4;
                DEPTH_8:  return 8;
                DEPTH_16: return 16;
                DEPTH_24: return 24;
                default:  return 32;
            endcase
        endfunction

        function void note_input(bpu_in_t item);
            int unsigned bpp, limit_x, rows, stride, len, y, per, shift, b, k;
            bit          upward;
            bit [7:0]    pixel_byte;
            bit [7:0]    idx;
            bit [15:0]   v;
            bit [31:0]   acc;
            bit [31:0]   colour;
            bpu_out_t    pixel;
            bpu_out_t    produced [$];

            if (item.mode == MODE_PALETTE) begin
                palette[item.palette_index] = item.data_word;
                live_items++;
                return;
            end

            bpp     = bits_per_pixel();
            limit_x = (width_reg == 0) ? 1 : width_reg;
            if (limit_x > MAX_DIMENSION) limit_x = MAX_DIMENSION;
            if (height_reg[HEIGHT_W-1]) begin
                rows   = (32'h4000 - height_reg) & 32'h3FFF;
                upward = 1'b0;
            end else begin
                rows   = height_reg;
                upward = 1'b1;
            end
            if (rows > MAX_DIMENSION) rows = MAX_DIMENSION;
            stride = (limit_x * bpp + 31) & ~32'd31;

            // Every data word counts towards the item total, including the
            // words that arrive after the final row.
            live_items++;

            acc = {8'h00, carry};
            len = carry_len;
            if (len > 24) begin
                acc = '0;
                len = 0;
            end

            for (b = 0; b < 4; b++) begin
                if (row >= rows) break;
                pixel_byte = item.data_word[8*b +: 8];
                y = upward ? (rows - 1 - row) : row;
                if (bpp <= 8) begin
                    // Paletted: pixels within a byte are most significant first.
                    per = 8 / bpp;
                    for (k = 0; k < per; k++) begin
                        shift = 8 - bpp * (k + 1);
                        idx   = 8'((pixel_byte >> shift) & ((1 << bpp) - 1));
                        if (column < limit_x && produced.size() < MAX_PIXELS) begin
                            pixel.pixel_x      = 12'(column);
                            pixel.pixel_y      = 12'(y);
                            pixel.colour_word  = palette[idx];
                            pixel.last_of_word = 1'b0;
                            produced.push_back(pixel);
                            column++;
                        end
                    end
                end else begin
                    // Direct colour: gather bytes, which may straddle words.
                    acc |= 32'(pixel_byte) << len;
                    len += 8;
                    if (len >= bpp) begin
                        if (bpp == 16) begin
                            v      = acc[15:0];
                            colour = {8'h00, v[14:10], 3'b000, v[9:5], 3'b000,
                                      v[4:0], 3'b000};
                        end else if (bpp == 24) begin
                            colour = acc & 32'h00FF_FFFF;
                        end else begin
                            colour = acc;
                        end
                        if (column < limit_x && produced.size() < MAX_PIXELS) begin
                            pixel.pixel_x      = 12'(column);
                            pixel.pixel_y      = 12'(y);
                            pixel.colour_word  = colour;
                            pixel.last_of_word = 1'b0;
                            produced.push_back(pixel);
                            column++;
                        end
                        acc = '0;
                        len = 0;
                    end
                end
                // End of the padded row: move to the next row, drop any carry.
                row_bits += 8;
                if (row_bits >= stride) begin
                    row_bits = 0;
                    column   = 0;
                    row++;
                    acc = '0;
                    len = 0;
                end
            end

            if (len > 24) begin
                acc = '0;
                len = 0;
            end
            carry     = acc[23:0];
            carry_len = len;

            if (produced.size() > 0)
                produced[produced.size() - 1].last_of_word = 1'b1;
            foreach (produced[i])
                expected_pixels.push_back(produced[i]);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] seen);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, seen);
            error_count++;
        endfunction

        function void check_result(bpu_out_t got);
            bpu_out_t want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d c=0x%0h",
                         $time, got.pixel_x, got.pixel_y, got.colour_word);
                error_count++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
            if (got.colour_word !== want.colour_word)
                report_field("colour_word", want.colour_word, got.colour_word);
            if (got.last_of_word !== want.last_of_word)
                report_field("last_of_word", 32'(want.last_of_word),
                             32'(got.last_of_word));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value so that nothing floats before the first edge.
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    bpu_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    bpu_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pixel_scoreboard        sb;
    int unsigned            idle_cycles = 0;
    bit                     progress;

    // Stimulus-side view of the palette: a pixel may only point at an entry
    // that has already been loaded, so the generator keeps its own record.
    bit                     palette_loaded [PALETTE_ENTRIES];
    int unsigned            loaded_list [$];
    logic [CODE_W-1:0]      stim_depth = DEPTH_8;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    bitmap_pixel_array_unpacker #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .PALETTE_DEPTH (PALETTE_ENTRIES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor. All three channels are sampled at the rising edge, before any
    // of this edge's nonblocking updates land, so the values seen are the
    // ones the block saw. A pixel is checked before the input of the same
    // edge is noted, since it can only belong to an earlier word. The same
    // block keeps the watchdog: a long spell with no transfer on any channel
    // means the block has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            progress = 1'b0;
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                progress = 1'b1;
            end
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.apply_register(cfg_index, cfg_data);
                progress = 1'b1;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Result side back-pressure: runs of readiness, occasionally very long
    // ones with no stall at all, broken by stalls of random length.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned stall;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
            repeat (run) begin
                @(posedge aclk);
                m_ready <= 1'b1;
            end
            stall = pause_length();
            repeat (stall) begin
                @(posedge aclk);
                m_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel index generation. A random index is tried first; failing that,
    // one of the loaded entries that fits the depth, and entry zero (loaded
    // at the very start) as the last resort.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_index(int unsigned bpp);
        int unsigned limit;
        int unsigned candidate;
        limit = 1 << bpp;
        repeat (8) begin
            candidate = $urandom_range(0, limit - 1);
            if (palette_loaded[candidate]) return 8'(candidate);
        end
        repeat (8) begin
            candidate = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            if (candidate < limit) return 8'(candidate);
        end
        return 8'd0;
    endfunction

    // A pixel-array word for the current depth. Paletted words are built
    // pixel by pixel, most significant first, from loaded entries only.
    function automatic logic [31:0] make_data_word();
        int unsigned bpp;
        logic [31:0] word;
        logic [7:0]  pixel_byte;
        if (stim_depth > DEPTH_8) return $urandom;
        bpp = 1 << stim_depth;
        word = '0;
        for (int b = 0; b < 4; b++) begin
            pixel_byte = '0;
            for (int k = 0; k < 8 / bpp; k++)
                pixel_byte = 8'((pixel_byte << bpp) | pick_index(bpp));
            word[8*b +: 8] = pixel_byte;
        end
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver. Called just after a rising edge; returns at the
    // edge where the transfer happens, leaving valid high so that a following
    // item can be presented at once without valid dropping in between.
    // ------------------------------------------------------------------------
    task automatic send_item(bpu_in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        if (item.mode == MODE_PALETTE && !palette_loaded[item.palette_index]) begin
            palette_loaded[item.palette_index] = 1'b1;
            loaded_list.push_back(item.palette_index);
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_palette(logic [7:0] index, logic [31:0] colour);
        bpu_in_t item;
        item.mode          = MODE_PALETTE;
        item.data_word     = colour;
        item.palette_index = index;
        send_item(item);
    endtask

    task automatic send_pixels(logic [31:0] word);
        bpu_in_t item;
        item.mode          = MODE_PIXELS;
        item.data_word     = word;
        item.palette_index = 8'($urandom);
        send_item(item);
    endtask

    task automatic hold_off(int unsigned cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Wait for every predicted pixel, then let any word that yields nothing
    // finish before the block is treated as idle.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write; like send_item it leaves valid high on return.
    task automatic post_register(logic [CFG_INDEX_W-1:0] index,
                                 logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure_image(logic [CFG_DATA_W-1:0] width_word,
                                   logic [CFG_DATA_W-1:0] height_word,
                                   logic [CFG_DATA_W-1:0] depth_word,
                                   bit spare);
        settle();
        post_register(CFG_WIDTH, width_word);
        post_register(CFG_HEIGHT, height_word);
        post_register(CFG_DEPTH, depth_word);
        if (spare) post_register(CFG_SPARE, 16'($urandom));
        cfg_valid  <= 1'b0;
        stim_depth = depth_word[CODE_W-1:0];
    endtask

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 13'd0;
                    1:       return 13'd1;
                    2:       return 13'd4096;
                    default: return 13'h1FFF;
                endcase
            end
            1:       return 13'($urandom);
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    // Heights are mostly a handful of rows either way up, so that images
    // finish and the words past the last row get exercised as well.
    function automatic logic [HEIGHT_W-1:0] pick_height();
        int magnitude;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 14'd0;
                    1:       return 14'h1FFF;
                    2:       return 14'h2000;
                    3:       return 14'd4096;
                    default: return 14'h3000;
                endcase
            end
            1: return 14'($urandom);
            default: begin
                magnitude = $urandom_range(1, 6);
                return $urandom_range(0, 1) ? 14'(magnitude) : 14'(-magnitude);
            end
        endcase
    endfunction

    // One random phase: a fresh image setting, then a burst of palette loads
    // and pixel words. About one phase in four runs without any input gaps.
    task automatic run_random_phase();
        int unsigned count;
        bit          no_gaps;
        bpu_in_t     item;
        configure_image({3'($urandom), pick_width()},
                        {2'($urandom), pick_height()},
                        {13'($urandom), 3'($urandom_range(0, 7))},
                        $urandom_range(0, 7) == 0);
        count   = $urandom_range(5, 30);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if ($urandom_range(0, 99) < 15) begin
                item.mode          = MODE_PALETTE;
                item.data_word     = $urandom;
                item.palette_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom);
            end else begin
                item.mode          = MODE_PIXELS;
                item.data_word     = make_data_word();
                item.palette_index = 8'($urandom);
            end
            send_item(item);
            if (!no_gaps) hold_off(pause_length());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Palette entries used by the directed words; entry zero must be
        // loaded first since the generator falls back on it.
        send_palette(8'd0, 32'h0010_2030);
        send_palette(8'd1, 32'h00FF_FFFF);
        send_palette(8'd2, 32'h0080_4020);
        send_palette(8'd3, 32'h0001_0203);
        send_palette(8'd255, 32'hFFFF_FFFF);

        // Reset setting: one 8-bit pixel per row, one row; the second word
        // arrives after the last row and must yield nothing.
        send_pixels(32'h0000_03FF);
        send_pixels(32'h1234_5678);

        // 1 bit per pixel, seven columns, two top-down rows; the final byte
        // pixel of each row lies beyond the width. Third word is past the end.
        configure_image(16'd7, 16'h3FFE, {13'd0, DEPTH_1}, 1'b0);
        send_pixels(32'hFFFF_FF80);
        send_pixels(32'h0000_007F);
        send_pixels(32'hDEAD_BEEF);

        // 2 bits per pixel across a byte boundary.
        configure_image(16'd5, 16'd1, {13'd0, DEPTH_2}, 1'b0);
        send_pixels(32'h0000_E41B);

        // 4 bits per pixel, bottom-up so the rows are flipped.
        configure_image(16'd3, 16'd2, {13'd0, DEPTH_4}, 1'b0);
        send_pixels(32'h0000_3012);
        send_pixels(32'h0000_0321);

        // 16 bits per pixel: the top bit of each pixel is dropped; the row
        // needs padding to the next word.
        configure_image(16'd3, 16'h3FFF, {13'd0, DEPTH_16}, 1'b0);
        send_pixels(32'hFFFF_7FFF);
        send_pixels(32'hABCD_8000);

        // 24 bits per pixel, pixels straddling word boundaries.
        configure_image(16'd3, 16'd1, {13'd0, DEPTH_24}, 1'b0);
        send_pixels(32'h3322_1100);
        send_pixels(32'h7766_5544);
        send_pixels(32'hBBAA_9988);

        // Zero width acts as one; an oversized positive height saturates.
        configure_image(16'd0, 16'h1FFF, {13'd0, DEPTH_32}, 1'b0);
        send_pixels(32'hFFFF_FFFF);
        send_pixels(32'h0000_0000);

        // Oversized width, zero height (no rows at all) and depth code seven,
        // plus a write to the spare register index.
        configure_image(16'h1FFF, 16'h0000, {13'd0, DEPTH_WIDE}, 1'b1);
        send_pixels(32'h5A5A_5A5A);

        target = sb.live_items + RANDOM_ITEMS;
        while (sb.live_items < target) run_random_phase();

        settle();
        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
